/* rtl/wte_pkg.sv */
package wte_pkg;

   localparam int TIME_W   = 40;
   localparam int BYTES_W  = 26;
   localparam int RATE_W   = 40;
   localparam int WINDOW_W = 32;
   localparam int CASE_W   = 2;
   localparam int US_W     = 20;

   localparam logic [US_W-1:0]     US_PER_S     = 20'd1000000;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd4000000;
   localparam logic [RATE_W-1:0]   RATE_MAX     = {RATE_W{1'b1}};

   // request kinds
   localparam logic REQ_RECORD = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   // decision cases
   localparam logic [CASE_W-1:0] CASE_EMPTY = 2'd0;
   localparam logic [CASE_W-1:0] CASE_FRESH = 2'd1;
   localparam logic [CASE_W-1:0] CASE_KEPT  = 2'd2;

   typedef struct packed {
      logic                is_query;
      logic [TIME_W-1:0]   start_us;
      logic [TIME_W-1:0]   end_us;
      logic [BYTES_W-1:0]  bytes;
      logic [TIME_W-1:0]   now_us;
   } item_type;

endpackage

/* rtl/wte_front.sv */
module wte_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  wte_pkg::item_type in_item,
   output logic              q_valid,
   input  logic              q_ready,
   output wte_pkg::item_type q_item
);
   import wte_pkg::*;

   // two-entry queue toward the back end
   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];
   assign push     = in_valid & in_ready;
   assign pop      = q_valid & q_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

/* rtl/wte_div.sv */
module wte_div #(
   parameter int NUM_W = 55,
   parameter int DEN_W = 46
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   // restoring divider, one quotient bit per cycle
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             ge;

   assign shifted = {rem_ff, num_ff[NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign ge      = (shifted >= {1'b0, den_ff});
   assign done    = done_ff;
   assign quot    = num_ff;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         num_in = {num_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

/* rtl/wte_back.sv */
module wte_back #(
   parameter int HISTORY_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [wte_pkg::WINDOW_W-1:0]   window_us,
   input  logic                           q_valid,
   output logic                           q_ready,
   input  wte_pkg::item_type              q_item,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [wte_pkg::RATE_W-1:0]     rsp_rate_bps,
   output logic [wte_pkg::CASE_W-1:0]     rsp_decision_case
);
   import wte_pkg::*;

   localparam int IDX_W  = $clog2(HISTORY_DEPTH);
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int BITS_W = BYTES_W + 3 + IDX_W;
   localparam int DUR_W  = TIME_W + IDX_W;
   localparam int PROD_W = BITS_W + US_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_LOAD  = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_RESP  = 3'd6;

   logic [TIME_W-1:0]  start_mem [HISTORY_DEPTH];
   logic [TIME_W-1:0]  end_mem   [HISTORY_DEPTH];
   logic [BYTES_W-1:0] bytes_mem [HISTORY_DEPTH];

   logic [2:0]         state_ff, state_in;
   logic [IDX_W-1:0]   wr_slot_ff, wr_slot_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [RATE_W-1:0]  last_est_ff, last_est_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [TIME_W-1:0]  t1_ff, t1_in;
   logic [IDX_W-1:0]   rd_slot_ff, rd_slot_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic               p1_valid_ff, p1_valid_in;
   logic               p1_last_ff, p1_last_in;
   logic [TIME_W-1:0]  rd_start_ff;
   logic [TIME_W-1:0]  rd_end_ff;
   logic [BYTES_W-1:0] rd_bytes_ff;
   logic               p2_valid_ff, p2_last_ff, p2_hit_ff, p2_sok_ff;
   logic [BITS_W-1:0]  p2_bits_ff;
   logic [TIME_W-1:0]  p2_dur_ff;
   logic               found_ff, found_in;
   logic [BITS_W-1:0]  acc_bits_ff, acc_bits_in;
   logic [DUR_W-1:0]   acc_dur_ff, acc_dur_in;
   logic               snap_ok_ff, snap_ok_in;
   logic [BITS_W-1:0]  snap_bits_ff, snap_bits_in;
   logic [DUR_W-1:0]   snap_dur_ff, snap_dur_in;
   logic [PROD_W-1:0]  prod_ff;
   logic [RATE_W-1:0]  res_rate_ff, res_rate_in;
   logic [CASE_W-1:0]  res_case_ff, res_case_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]  rsp_rate_ff;
   logic [CASE_W-1:0]  rsp_case_ff;

   logic               take_q, write_rec;
   logic [CNT_W:0]     oldest_wide;
   logic               take_row;
   logic [BITS_W-1:0]  sum_bits;
   logic [DUR_W-1:0]   sum_dur;
   logic               div_start, div_done;
   logic [PROD_W-1:0]  div_quot;
   logic [RATE_W-1:0]  sat_rate;
   logic               rsp_load;

   assign q_ready   = (state_ff == ST_IDLE);
   assign take_q    = q_valid & q_ready;
   assign write_rec = take_q & (q_item.is_query == REQ_RECORD);
   assign div_start = (state_ff == ST_LOAD);
   assign rsp_load  = (state_ff == ST_RESP) & (~rsp_valid_ff | rsp_ready);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rate_bps      = rsp_rate_ff;
   assign rsp_decision_case = rsp_case_ff;

   // oldest retained slot
   always_comb begin
      if ((CNT_W+1)'(wr_slot_ff) >= (CNT_W+1)'(count_ff))
         oldest_wide = (CNT_W+1)'(wr_slot_ff) - (CNT_W+1)'(count_ff);
      else
         oldest_wide = (CNT_W+1)'(wr_slot_ff) + (CNT_W+1)'(HISTORY_DEPTH)
                       - (CNT_W+1)'(count_ff);
   end

   // running sums from the first hit onward
   assign take_row = found_ff | p2_hit_ff;
   assign sum_bits = (found_ff ? acc_bits_ff : '0) + p2_bits_ff;
   assign sum_dur  = (found_ff ? acc_dur_ff : '0) + DUR_W'(p2_dur_ff);

   assign sat_rate = (|div_quot[PROD_W-1:RATE_W]) ? RATE_MAX : div_quot[RATE_W-1:0];

   wte_div #(
      .NUM_W (PROD_W),
      .DEN_W (DUR_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (prod_ff),
      .den   (snap_dur_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      wr_slot_in   = wr_slot_ff;
      count_in     = count_ff;
      last_est_in  = last_est_ff;
      now_in       = now_ff;
      t1_in        = t1_ff;
      rd_slot_in   = rd_slot_ff;
      left_in      = left_ff;
      p1_valid_in  = 1'b0;
      p1_last_in   = 1'b0;
      found_in     = found_ff;
      acc_bits_in  = acc_bits_ff;
      acc_dur_in   = acc_dur_ff;
      snap_ok_in   = snap_ok_ff;
      snap_bits_in = snap_bits_ff;
      snap_dur_in  = snap_dur_ff;
      res_rate_in  = res_rate_ff;
      res_case_in  = res_case_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready)
         rsp_valid_in = 1'b0;

      if (p2_valid_ff && take_row) begin
         found_in    = 1'b1;
         acc_bits_in = sum_bits;
         acc_dur_in  = sum_dur;
         if (p2_sok_ff) begin
            snap_ok_in   = 1'b1;
            snap_bits_in = sum_bits;
            snap_dur_in  = sum_dur;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (write_rec) begin
               wr_slot_in = (wr_slot_ff == IDX_W'(HISTORY_DEPTH - 1)) ? '0
                            : wr_slot_ff + 1'b1;
               if (count_ff < CNT_W'(HISTORY_DEPTH))
                  count_in = count_ff + 1'b1;
            end else if (take_q) begin
               if (count_ff == '0) begin
                  res_rate_in = last_est_ff;
                  res_case_in = CASE_EMPTY;
                  state_in    = ST_RESP;
               end else begin
                  now_in     = q_item.now_us;
                  t1_in      = (q_item.now_us >= TIME_W'(window_us))
                               ? q_item.now_us - TIME_W'(window_us) : '0;
                  rd_slot_in = oldest_wide[IDX_W-1:0];
                  left_in    = count_ff;
                  found_in   = 1'b0;
                  snap_ok_in = 1'b0;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            p1_valid_in = 1'b1;
            p1_last_in  = (left_ff == CNT_W'(1));
            rd_slot_in  = (rd_slot_ff == IDX_W'(HISTORY_DEPTH - 1)) ? '0
                          : rd_slot_ff + 1'b1;
            left_in     = left_ff - 1'b1;
            if (left_ff == CNT_W'(1))
               state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (p2_valid_ff && p2_last_ff)
               state_in = ST_MUL;
         end
         ST_MUL: begin
            if (!snap_ok_ff || snap_dur_ff == '0) begin
               res_rate_in = last_est_ff;
               res_case_in = CASE_KEPT;
               state_in    = ST_RESP;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               last_est_in = sat_rate;
               res_rate_in = sat_rate;
               res_case_in = CASE_FRESH;
               state_in    = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_slot_ff   <= '0;
         count_ff     <= '0;
         last_est_ff  <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_slot_ff   <= wr_slot_in;
         count_ff     <= count_in;
         last_est_ff  <= last_est_in;
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      t1_ff        <= t1_in;
      rd_slot_ff   <= rd_slot_in;
      left_ff      <= left_in;
      p1_last_ff   <= p1_last_in;
      found_ff     <= found_in;
      acc_bits_ff  <= acc_bits_in;
      acc_dur_ff   <= acc_dur_in;
      snap_ok_ff   <= snap_ok_in;
      snap_bits_ff <= snap_bits_in;
      snap_dur_ff  <= snap_dur_in;
      res_rate_ff  <= res_rate_in;
      res_case_ff  <= res_case_in;
      // per-row terms
      p2_last_ff   <= p1_last_ff;
      p2_hit_ff    <= (rd_end_ff >= t1_ff);
      p2_sok_ff    <= (rd_start_ff <= now_ff);
      p2_bits_ff   <= BITS_W'({rd_bytes_ff, 3'b000});
      p2_dur_ff    <= (rd_end_ff > rd_start_ff) ? rd_end_ff - rd_start_ff : '0;
      prod_ff      <= PROD_W'(snap_bits_ff) * PROD_W'(US_PER_S);
      if (rsp_load) begin
         rsp_rate_ff <= res_rate_ff;
         rsp_case_ff <= res_case_ff;
      end
   end

   // history memories
   always_ff @(posedge clock) begin
      if (write_rec) begin
         start_mem[wr_slot_ff] <= q_item.start_us;
         end_mem[wr_slot_ff]   <= q_item.end_us;
         bytes_mem[wr_slot_ff] <= q_item.bytes;
      end
      rd_start_ff <= start_mem[rd_slot_ff];
      rd_end_ff   <= end_mem[rd_slot_ff];
      rd_bytes_ff <= bytes_mem[rd_slot_ff];
   end

endmodule

/* rtl/windowed_throughput_estimator_unit.sv */
// channel   direction  transaction
// req_*     in         record (start, end, bytes) or query (now)
// rsp_*     out        rate_bps and decision_case, one per query
// csr_*     in         window_us write, no wait
//
// a record is written as the back end takes it; a query scans the retained
// records, drains the read pipeline, multiplies and runs the divider, then
// answers; empty history or no overlap answers with the last estimate and no
// divider; a two-entry queue lets requests land while the back end is busy
// the result register holds a response under rsp_ready low; reset is
// synchronous and clears control, the history memories start unwritten
module windowed_throughput_estimator_unit #(
   parameter int HISTORY_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [wte_pkg::TIME_W-1:0]          req_xfer_start_us,
   input  logic [wte_pkg::TIME_W-1:0]          req_xfer_end_us,
   input  logic [wte_pkg::BYTES_W-1:0]         req_xfer_bytes,
   input  logic [wte_pkg::TIME_W-1:0]          req_now_us,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [wte_pkg::RATE_W-1:0]          rsp_rate_bps,
   output logic [wte_pkg::CASE_W-1:0]          rsp_decision_case,
   input  logic                                csr_we,
   input  logic [wte_pkg::WINDOW_W-1:0]        csr_wdata
);
   import wte_pkg::*;

   // window length register
   logic [WINDOW_W-1:0] window_ff, window_in;
   item_type            in_item;
   item_type            q_item;
   logic                q_valid, q_ready;

   assign window_in = csr_we ? csr_wdata : window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   // pack the request fields
   always_comb begin
      in_item.is_query = req_type;
      in_item.start_us = req_xfer_start_us;
      in_item.end_us   = req_xfer_end_us;
      in_item.bytes    = req_xfer_bytes;
      in_item.now_us   = req_now_us;
   end

   wte_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .in_item  (in_item),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_item   (q_item)
   );

   wte_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .window_us         (window_ff),
      .q_valid           (q_valid),
      .q_ready           (q_ready),
      .q_item            (q_item),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_rate_bps      (rsp_rate_bps),
      .rsp_decision_case (rsp_decision_case)
   );

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // only the three defined decision cases leave the block
   a_case_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_decision_case == CASE_EMPTY ||
                     rsp_decision_case == CASE_FRESH ||
                     rsp_decision_case == CASE_KEPT))
      else $error("undefined decision case");

   // internal queue holds its head while the back end is busy
   a_queue_hold: assert property (@(posedge clock) disable iff (reset)
      q_valid && !q_ready |=> q_valid && $stable(q_item))
      else $error("queue head lost while stalled");

endmodule
